>>> rtl/pdrt_pkg.sv
// ----------------------------------------------------------------------------
// pdrt_pkg
// Shared widths, register map, reset values and the countdown step for the
// prescaled divider and reload timer.
// ----------------------------------------------------------------------------
package pdrt_pkg;

    localparam int PERIOD_WIDTH = 16;
    localparam int ADDR_WIDTH   = 5;
    localparam int DATA_WIDTH   = 32;
    localparam int REG_W        = 16;

    typedef logic [PERIOD_WIDTH-1:0] t_period;
    typedef logic [7:0]              t_byte;
    typedef logic [2:0]              t_reg_idx;

    localparam t_reg_idx REG_DIV_PERIOD = 3'd0;
    localparam t_reg_idx REG_PERIOD_S0  = 3'd1;
    localparam t_reg_idx REG_PERIOD_S1  = 3'd2;
    localparam t_reg_idx REG_PERIOD_S2  = 3'd3;
    localparam t_reg_idx REG_PERIOD_S3  = 3'd4;
    localparam t_reg_idx REG_TMR_EN     = 3'd5;
    localparam t_reg_idx REG_CLK_SEL    = 3'd6;
    localparam t_reg_idx REG_RELOAD     = 3'd7;

    localparam logic [1:0] SEL_0 = 2'b00;
    localparam logic [1:0] SEL_1 = 2'b01;
    localparam logic [1:0] SEL_2 = 2'b10;

    localparam t_byte COUNT_MAX = 8'hff;

    localparam t_period RST_DIV_PERIOD = t_period'(REG_W'(256));
    localparam t_period RST_PERIOD_S0  = t_period'(REG_W'(1024));
    localparam t_period RST_PERIOD_S1  = t_period'(REG_W'(16));
    localparam t_period RST_PERIOD_S2  = t_period'(REG_W'(64));
    localparam t_period RST_PERIOD_S3  = t_period'(REG_W'(256));

    typedef struct packed {
        logic    tick;
        logic    over;
        t_period rem;
    } t_cd_result;

    function automatic t_cd_result count_down(t_period rem, t_period period, t_byte n);
        t_cd_result res;
        t_byte      excess;
        res.tick = 1'b0;
        res.over = 1'b0;
        excess   = n - t_byte'(rem);
        if ({{PERIOD_WIDTH{1'b0}}, 8'd0} + rem <= {{PERIOD_WIDTH{1'b0}}, n}) begin
            res.tick = 1'b1;
            if ({{PERIOD_WIDTH{1'b0}}, excess} > {8'd0, period}) begin
                res.rem  = '0;
                res.over = 1'b1;
            end else begin
                res.rem = period - t_period'(excess);
            end
        end else begin
            res.rem = rem - t_period'(n);
        end
        return res;
    endfunction

endpackage

>>> rtl/prescaled_divider_and_reload_timer.sv
// ----------------------------------------------------------------------------
// prescaled_divider_and_reload_timer
// Free-running divider and reloadable 8-bit timer driven by pulse counts.
// ----------------------------------------------------------------------------
// channel  | direction | handshake                  | payload
// in       | input     | i_in_valid / o_in_ready    | i_pulse_count
// out      | output    | o_out_valid / i_out_ready  | o_div_value, o_timer_value,
//          |           |                            | o_timer_interrupt, o_pulse_overrun
// cfg      | input     | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// One transaction per cycle unless the output stalls (input register, result register).
// The countdown state updates as a transaction moves from the input register
// into the result register. A stalled output holds the input register; the
// input side keeps accepting while the result register drains.
// Synchronous active-low reset loads the register and state reset values.
module prescaled_divider_and_reload_timer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_pulse_count,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [7:0]                    o_div_value,
    output logic [7:0]                    o_timer_value,
    output logic                          o_timer_interrupt,
    output logic                          o_pulse_overrun,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pdrt_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [pdrt_pkg::DATA_WIDTH-1:0] pwdata,
    output logic [pdrt_pkg::DATA_WIDTH-1:0] prdata,
    output logic                          pready
);
    import pdrt_pkg::*;

    t_period  r_div_period;
    t_period  r_period [4];
    logic     r_tmr_en;
    logic [1:0] r_clk_sel;
    t_byte    r_reload;

    t_period  r_div_rem, n_div_rem;
    t_period  r_tmr_rem, n_tmr_rem;
    t_period  r_act_period, n_act_period;
    t_byte    r_div_cnt, n_div_cnt;
    t_byte    r_tmr_cnt, n_tmr_cnt;

    logic     r_in_vld;
    t_byte    r_in_cnt;
    logic     r_out_vld;
    logic     r_out_irq, n_out_irq;
    logic     r_out_over, n_out_over;

    logic       w_move;
    logic       w_wr;
    t_reg_idx   w_idx;
    t_period    w_wval;
    t_period    w_sel_period;
    t_period    w_tmr_start;
    t_cd_result w_div_cd;
    t_cd_result w_tmr_cd;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = paddr[ADDR_WIDTH-1:2];
    assign w_wval = t_period'(pwdata[REG_W-1:0]);

    always_comb begin
        prdata = '0;
        case (w_idx)
            REG_DIV_PERIOD: prdata = DATA_WIDTH'(r_div_period);
            REG_PERIOD_S0:  prdata = DATA_WIDTH'(r_period[0]);
            REG_PERIOD_S1:  prdata = DATA_WIDTH'(r_period[1]);
            REG_PERIOD_S2:  prdata = DATA_WIDTH'(r_period[2]);
            REG_PERIOD_S3:  prdata = DATA_WIDTH'(r_period[3]);
            REG_TMR_EN:     prdata = DATA_WIDTH'(r_tmr_en);
            REG_CLK_SEL:    prdata = DATA_WIDTH'(r_clk_sel);
            REG_RELOAD:     prdata = DATA_WIDTH'(r_reload);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_period <= RST_DIV_PERIOD;
            r_period[0]  <= RST_PERIOD_S0;
            r_period[1]  <= RST_PERIOD_S1;
            r_period[2]  <= RST_PERIOD_S2;
            r_period[3]  <= RST_PERIOD_S3;
            r_tmr_en     <= 1'b0;
            r_clk_sel    <= SEL_0;
            r_reload     <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_DIV_PERIOD: r_div_period <= w_wval;
                REG_PERIOD_S0:  r_period[0]  <= w_wval;
                REG_PERIOD_S1:  r_period[1]  <= w_wval;
                REG_PERIOD_S2:  r_period[2]  <= w_wval;
                REG_PERIOD_S3:  r_period[3]  <= w_wval;
                REG_TMR_EN:     r_tmr_en     <= pwdata[0];
                REG_CLK_SEL:    r_clk_sel    <= pwdata[1:0];
                REG_RELOAD:     r_reload     <= pwdata[7:0];
                default:        ;
            endcase
        end
    end

    // pipeline control
    assign w_move     = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || w_move;

    always_comb begin
        case (r_clk_sel)
            SEL_0:   w_sel_period = r_period[0];
            SEL_1:   w_sel_period = r_period[1];
            SEL_2:   w_sel_period = r_period[2];
            default: w_sel_period = r_period[3];
        endcase
    end

    assign w_tmr_start = (r_act_period != w_sel_period) ? w_sel_period : r_tmr_rem;
    assign w_div_cd    = count_down(r_div_rem, r_div_period, r_in_cnt);
    assign w_tmr_cd    = count_down(w_tmr_start, w_sel_period, r_in_cnt);

    always_comb begin
        n_div_rem    = w_div_cd.rem;
        n_div_cnt    = r_div_cnt + t_byte'(w_div_cd.tick);
        n_tmr_rem    = r_tmr_rem;
        n_act_period = r_act_period;
        n_tmr_cnt    = r_tmr_cnt;
        n_out_irq    = 1'b0;
        n_out_over   = w_div_cd.over;
        if (r_tmr_en) begin
            n_act_period = w_sel_period;
            n_tmr_rem    = w_tmr_cd.rem;
            n_out_over   = w_div_cd.over || w_tmr_cd.over;
            if (w_tmr_cd.tick) begin
                if (r_tmr_cnt != COUNT_MAX) begin
                    n_tmr_cnt = r_tmr_cnt + 8'd1;
                end else begin
                    n_tmr_cnt = r_reload;
                    n_out_irq = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
            r_div_rem    <= RST_DIV_PERIOD;
            r_tmr_rem    <= RST_PERIOD_S0;
            r_act_period <= RST_PERIOD_S0;
            r_div_cnt    <= '0;
            r_tmr_cnt    <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (w_move) begin
                r_out_vld    <= 1'b1;
                r_div_rem    <= n_div_rem;
                r_tmr_rem    <= n_tmr_rem;
                r_act_period <= n_act_period;
                r_div_cnt    <= n_div_cnt;
                r_tmr_cnt    <= n_tmr_cnt;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_cnt <= i_pulse_count;
        end
        if (w_move) begin
            r_out_irq  <= n_out_irq;
            r_out_over <= n_out_over;
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_div_value       = r_div_cnt;
    assign o_timer_value     = r_tmr_cnt;
    assign o_timer_interrupt = r_out_irq;
    assign o_pulse_overrun   = r_out_over;

`ifndef SYNTHESIS
    a_irq_needs_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_move |=> (!o_timer_interrupt || r_tmr_en))
        else $error("interrupt raised with timer disabled");

    a_irq_reloads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_move |=> (!o_timer_interrupt || o_timer_value == r_reload))
        else $error("interrupt without reload of timer value");

    a_overrun_clamps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_move |=> (!o_pulse_overrun || r_div_rem == '0 || r_tmr_rem == '0))
        else $error("overrun flagged without a clamped remainder");

    a_div_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_move |=> (r_div_cnt == $past(r_div_cnt) || r_div_cnt == $past(r_div_cnt) + 8'd1))
        else $error("divider value stepped by more than one");

    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_move && i_rst_n) |=> ($stable(r_div_cnt) && $stable(r_tmr_cnt) && $stable(r_div_rem)))
        else $error("countdown state changed without a transaction");
`endif

endmodule

>>> verif/tb_prescaled_divider_and_reload_timer.sv
// ----------------------------------------------------------------------------
// tb_prescaled_divider_and_reload_timer
// Self-checking bench for the prescaled divider and reload timer. A local
// model of the divider and timer countdowns predicts every result from each
// accepted input transaction. Registers are set over APB once results drain.
// Both handshake sides idle at random, and the output is also held off for
// long stretches.
// ----------------------------------------------------------------------------
module tb_prescaled_divider_and_reload_timer;
    timeunit 1ns;
    timeprecision 1ps;

    import pdrt_pkg::*;

    localparam int CYCLE_LIMIT = 500000;

    typedef struct packed {
        t_byte div_value;
        t_byte timer_value;
        logic  timer_interrupt;
        logic  pulse_overrun;
    } t_counts;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [7:0]            i_pulse_count = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [7:0]            o_div_value;
    logic [7:0]            o_timer_value;
    logic                  o_timer_interrupt;
    logic                  o_pulse_overrun;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_WIDTH-1:0] paddr = '0;
    logic [DATA_WIDTH-1:0] pwdata = '0;
    logic [DATA_WIDTH-1:0] prdata;
    logic                  pready;

    prescaled_divider_and_reload_timer uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_pulse_count     (i_pulse_count),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_div_value       (o_div_value),
        .o_timer_value     (o_timer_value),
        .o_timer_interrupt (o_timer_interrupt),
        .o_pulse_overrun   (o_pulse_overrun),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always #2 i_clk = ~i_clk;

    // register shadow
    t_period cfg_div_period;
    t_period cfg_period [4];
    logic    cfg_enable;
    logic [1:0] cfg_sel;
    t_byte   cfg_reload;

    // countdown state
    t_period div_rem;
    t_period tmr_rem;
    t_period active_per;
    t_byte   div_cnt;
    t_byte   tmr_cnt;

    t_counts pending_counts [$];
    int      error_count = 0;
    int      cycle_count = 0;
    bit      in_idle = 1'b0;
    bit      out_idle = 1'b0;
    bit      cfg_noise = 1'b0;
    int      hold_left = 0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic void reset_counts();
        cfg_div_period = RST_DIV_PERIOD;
        cfg_period[0]  = RST_PERIOD_S0;
        cfg_period[1]  = RST_PERIOD_S1;
        cfg_period[2]  = RST_PERIOD_S2;
        cfg_period[3]  = RST_PERIOD_S3;
        cfg_enable     = 1'b0;
        cfg_sel        = SEL_0;
        cfg_reload     = '0;
        div_rem        = RST_DIV_PERIOD;
        active_per     = RST_PERIOD_S0;
        tmr_rem        = RST_PERIOD_S0;
        div_cnt        = '0;
        tmr_cnt        = '0;
    endfunction

    function automatic bit countdown(inout t_period rem, input t_period per,
                                     input t_byte n, inout bit over);
        int unsigned excess;
        if (rem <= n) begin
            excess = n - rem;
            if (excess > per) begin
                rem  = '0;
                over = 1'b1;
            end else begin
                rem = t_period'(per - excess);
            end
            return 1'b1;
        end
        rem = rem - t_period'(n);
        return 1'b0;
    endfunction

    function automatic t_counts advance_counts(t_byte n);
        t_counts res;
        bit      over;
        bit      irq;
        t_period sel_per;
        over = 1'b0;
        irq  = 1'b0;
        if (countdown(div_rem, cfg_div_period, n, over))
            div_cnt = div_cnt + 8'd1;
        if (cfg_enable) begin
            sel_per = cfg_period[cfg_sel];
            if (active_per != sel_per) begin
                active_per = sel_per;
                tmr_rem    = sel_per;
            end
            if (countdown(tmr_rem, sel_per, n, over)) begin
                if (tmr_cnt != COUNT_MAX) begin
                    tmr_cnt = tmr_cnt + 8'd1;
                end else begin
                    tmr_cnt = cfg_reload;
                    irq     = 1'b1;
                end
            end
        end
        res.div_value       = div_cnt;
        res.timer_value     = tmr_cnt;
        res.timer_interrupt = irq;
        res.pulse_overrun   = over;
        return res;
    endfunction

    function automatic void check_counts();
        t_counts exp_c;
        if (pending_counts.size() == 0) begin
            $error("unexpected result transaction: div %0d timer %0d",
                   o_div_value, o_timer_value);
            error_count++;
            return;
        end
        exp_c = pending_counts.pop_front();
        if (o_div_value !== exp_c.div_value) begin
            $error("div_value: expected %0d, actual %0d", exp_c.div_value, o_div_value);
            error_count++;
        end
        if (o_timer_value !== exp_c.timer_value) begin
            $error("timer_value: expected %0d, actual %0d", exp_c.timer_value,
                   o_timer_value);
            error_count++;
        end
        if (o_timer_interrupt !== exp_c.timer_interrupt) begin
            $error("timer_interrupt: expected %0b, actual %0b", exp_c.timer_interrupt,
                   o_timer_interrupt);
            error_count++;
        end
        if (o_pulse_overrun !== exp_c.pulse_overrun) begin
            $error("pulse_overrun: expected %0b, actual %0b", exp_c.pulse_overrun,
                   o_pulse_overrun);
            error_count++;
        end
    endfunction

    // result side: checks each transaction and draws its stall
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && i_out_ready && o_out_valid) begin
                check_counts();
                stall_left = out_idle ? $urandom_range(0, 9) : 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic send_pulses(input t_byte pc);
        int gap;
        gap = in_idle ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_pulse_count <= pc;
        do @(posedge i_clk); while (!o_in_ready);
        pending_counts.push_back(advance_counts(pc));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_counts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_reg_idx idx, input logic [31:0] value);
        logic [31:0] field_mask;
        logic [31:0] wdata;
        wait_drained();
        case (idx)
            REG_TMR_EN:  field_mask = 32'h1;
            REG_CLK_SEL: field_mask = 32'h3;
            REG_RELOAD:  field_mask = 32'hff;
            default:     field_mask = 32'hffff;
        endcase
        wdata = value & field_mask;
        if (cfg_noise)
            wdata = wdata | ($urandom() & ~field_mask);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_WIDTH'({idx, 2'b00});
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_DIV_PERIOD: cfg_div_period = t_period'(wdata[15:0]);
            REG_PERIOD_S0:  cfg_period[0]  = t_period'(wdata[15:0]);
            REG_PERIOD_S1:  cfg_period[1]  = t_period'(wdata[15:0]);
            REG_PERIOD_S2:  cfg_period[2]  = t_period'(wdata[15:0]);
            REG_PERIOD_S3:  cfg_period[3]  = t_period'(wdata[15:0]);
            REG_TMR_EN:     cfg_enable     = wdata[0];
            REG_CLK_SEL:    cfg_sel        = wdata[1:0];
            REG_RELOAD:     cfg_reload     = wdata[7:0];
            default: ;
        endcase
    endtask

    function automatic logic [15:0] pick_period(int kind);
        case (kind)
            0: return 16'($urandom_range(1, 40));
            1: return 16'($urandom_range(1, 600));
            2: begin
                case ($urandom_range(0, 3))
                    0:       return 16'd0;
                    1:       return 16'd1;
                    2:       return 16'hffff;
                    default: return 16'($urandom_range(2, 255));
                endcase
            end
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic test_directed_cases();
        in_idle  = 1'b0;
        out_idle = 1'b0;
        // divider with reset period, timer disabled
        send_pulses(8'd0);
        send_pulses(8'd255);
        send_pulses(8'd1);
        // excess equal to the period, then zero remaining ticks on zero pulses
        cfg_write(REG_DIV_PERIOD, 32'd4);
        send_pulses(8'd255);
        send_pulses(8'd5);
        send_pulses(8'd0);
        send_pulses(8'd255);
        send_pulses(8'd0);
        // zero period
        cfg_write(REG_DIV_PERIOD, 32'd0);
        send_pulses(8'd3);
        send_pulses(8'd0);
        send_pulses(8'd255);
        // timer on select 1, then select 2 with the same period: no restart
        cfg_write(REG_DIV_PERIOD, 32'd65535);
        cfg_write(REG_PERIOD_S2, 32'd16);
        cfg_write(REG_CLK_SEL, 32'd1);
        cfg_write(REG_TMR_EN, 32'd1);
        send_pulses(8'd20);
        send_pulses(8'd5);
        cfg_write(REG_CLK_SEL, 32'd2);
        send_pulses(8'd3);
        send_pulses(8'd15);
        // select change with a new period restarts the countdown
        cfg_write(REG_PERIOD_S3, 32'd65535);
        cfg_write(REG_CLK_SEL, 32'd3);
        send_pulses(8'd255);
        cfg_write(REG_PERIOD_S0, 32'd0);
        cfg_write(REG_CLK_SEL, 32'd0);
        send_pulses(8'd1);
        send_pulses(8'd0);
        // timer frozen while disabled
        cfg_write(REG_RELOAD, 32'd255);
        cfg_write(REG_TMR_EN, 32'd0);
        send_pulses(8'd255);
        send_pulses(8'd255);
        wait_drained();
    endtask

    task automatic test_random_phases();
        int   kind;
        int   pmax;
        int   count;
        t_byte pc;
        for (int ph = 0; ph < 12; ph++) begin
            cfg_noise = ph[0];
            kind = (ph < 4) ? 0 : $urandom_range(0, 3);
            if ($urandom_range(0, 2) == 0)
                kind = 0;
            cfg_write(REG_DIV_PERIOD, 32'(pick_period(kind)));
            cfg_write(REG_PERIOD_S0, 32'(pick_period(kind)));
            cfg_write(REG_PERIOD_S1, 32'(pick_period(kind)));
            cfg_write(REG_PERIOD_S2, 32'(pick_period($urandom_range(0, 1) ? kind : 0)));
            cfg_write(REG_PERIOD_S3, 32'(pick_period(kind)));
            cfg_write(REG_CLK_SEL, $urandom_range(0, 3));
            case ($urandom_range(0, 3))
                0:       cfg_write(REG_RELOAD, $urandom_range(0, 255));
                1:       cfg_write(REG_RELOAD, ph[1] ? 32'd0 : 32'd255);
                default: cfg_write(REG_RELOAD, $urandom_range(240, 255));
            endcase
            cfg_write(REG_TMR_EN, (ph % 5 == 4) ? 32'd0 : 32'd1);
            in_idle  = (ph == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
            out_idle = (ph == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
            pmax  = $urandom_range(0, 1) ? 255 : 40;
            count = 80 + $urandom_range(0, 10);
            for (int k = 0; k < count; k++) begin
                if (k == count / 2 && $urandom_range(0, 1))
                    cfg_write(REG_CLK_SEL, $urandom_range(0, 3));
                case ($urandom_range(0, 9))
                    0:       pc = 8'd0;
                    1:       pc = 8'd255;
                    default: pc = t_byte'($urandom_range(0, pmax));
                endcase
                send_pulses(pc);
            end
        end
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        in_idle  = 1'b0;
        out_idle = 1'b1;
        cfg_noise = 1'b0;
        cfg_write(REG_PERIOD_S1, 32'd7);
        cfg_write(REG_CLK_SEL, 32'd1);
        cfg_write(REG_TMR_EN, 32'd1);
        @(posedge i_clk);
        hold_left = 60;
        for (int k = 0; k < 30; k++)
            send_pulses(t_byte'($urandom()));
        wait_drained();
    endtask

    task automatic test_sender_pause();
        in_idle  = 1'b1;
        out_idle = 1'b1;
        for (int k = 0; k < 10; k++)
            send_pulses(t_byte'($urandom()));
        wait_drained();
        for (int k = 0; k < 10; k++)
            send_pulses(t_byte'($urandom()));
        wait_drained();
    endtask

    initial begin
        reset_counts();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_random_phases();
        test_output_backpressure();
        test_sender_pause();
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (error_count == 0 && pending_counts.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/pdrt_pkg.sv
rtl/prescaled_divider_and_reload_timer.sv
verif/tb_prescaled_divider_and_reload_timer.sv
